@@ hw/rtl/p2d_pkg.sv @@
// Shared types, constants and fixed-point helpers for the 2-D polynomial surface evaluator.
// No dependencies.
package p2d_pkg;

    localparam int DEF_ORDER_CAP   = 7;
    localparam int DEF_COEFF_SLOTS = 36;
    localparam int DEF_MAX_DIM     = 4096;

    localparam logic signed [31:0] Q28_ONE = 32'sh1000_0000;

    // configuration register indexes
    localparam logic [2:0] CFG_ORDER_X    = 3'd0;
    localparam logic [2:0] CFG_ORDER_Y    = 3'd1;
    localparam logic [2:0] CFG_ROW_OFFSET = 3'd2;
    localparam logic [2:0] CFG_COL_OFFSET = 3'd3;
    localparam logic [2:0] CFG_ROW_SCALE  = 3'd4;
    localparam logic [2:0] CFG_COL_SCALE  = 3'd5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COORD,
        ST_RUN,
        ST_FLUSH,
        ST_DRAIN
    } t_state;

    // control handed to each coefficient cell
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic signed [31:0] value;
        logic               sat;
    } t_q28_res;

    // (a*b) >> 28, floor, saturated to 32 bits
    function automatic t_q28_res mul_q28(input logic signed [31:0] a,
                                         input logic signed [31:0] b);
        logic signed [63:0] prod;
        logic signed [35:0] sh;
        t_q28_res           res;
        prod = a * b;
        sh   = prod[63:28];
        res.sat = !((&sh[35:31]) || (~|sh[35:31]));
        if (res.sat) begin
            res.value = sh[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            res.value = sh[31:0];
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/poly2d_surface_evaluator.sv @@
// Top level of the 2-D polynomial surface evaluator: ring of coefficient cells,
// coordinate units, monomial/term sequencer and saturating accumulator.
// Depends on p2d_pkg, p2d_cell, p2d_coord.
//
// Load words (tuser = 0) write one Q16.16 coefficient into its cell.
// An evaluate word (tuser = 1) is worked on alone: a coordinate state (ST_COORD),
// then the coefficient ring rotates past the head cell, one slot a cycle, while
// the monomial chain advances beside it; the run (ST_RUN) lasts until every term
// is issued and the ring has made a full turn so that it ends back at home,
// followed by an accumulate state (ST_FLUSH) and an output state (ST_DRAIN).
// The next word is taken only once the evaluate is back in ST_IDLE, so the ring
// rotation bounds how closely evaluates can follow one another. The result
// waits in an output register; the next input word is taken meanwhile, and a new
// evaluate stalls only at its end if the previous result is still untaken.
// Coefficient cells clear at reset.
module poly2d_surface_evaluator
    import p2d_pkg::*;
#(
    parameter int ORDER_CAP   = DEF_ORDER_CAP,
    parameter int COEFF_SLOTS = DEF_COEFF_SLOTS,
    parameter int MAX_DIM     = DEF_MAX_DIM
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input words
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // coeff_index[5:0], coeff_value[37:6], row[49:38], col[61:50]
    input  logic        i_s_tuser,   // op
    // result words
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // surface_value[47:0]
    output logic        o_m_tuser    // saturated
);

    localparam int OW        = $clog2(ORDER_CAP + 2);
    localparam int MAX_TERMS = (ORDER_CAP + 1) * (ORDER_CAP + 2) / 2;
    localparam int SEQ_MAX   = (MAX_TERMS > COEFF_SLOTS) ? MAX_TERMS : COEFF_SLOTS;
    localparam int SW        = $clog2(SEQ_MAX + 1);

    // configuration registers
    logic [2:0]         r_order_x, r_order_y;
    logic signed [17:0] r_row_offset, r_col_offset;
    logic signed [31:0] r_row_scale, r_col_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_x    <= '0;
            r_order_y    <= '0;
            r_row_offset <= '0;
            r_col_offset <= '0;
            r_row_scale  <= Q28_ONE;
            r_col_scale  <= Q28_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ORDER_X:    r_order_x    <= i_cfg_data[2:0];
                CFG_ORDER_Y:    r_order_y    <= i_cfg_data[2:0];
                CFG_ROW_OFFSET: r_row_offset <= i_cfg_data[17:0];
                CFG_COL_OFFSET: r_col_offset <= i_cfg_data[17:0];
                CFG_ROW_SCALE:  r_row_scale  <= i_cfg_data;
                CFG_COL_SCALE:  r_col_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input word fields
    logic [5:0]         in_cidx;
    logic signed [31:0] in_cval;
    logic [11:0]        in_row, in_col;
    logic               accept;

    assign in_cidx = i_s_tdata[5:0];
    assign in_cval = i_s_tdata[37:6];
    assign in_row  = i_s_tdata[49:38];
    assign in_col  = i_s_tdata[61:50];

    t_state r_state, n_state;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    // coordinate units, loaded as an evaluate word is accepted
    logic signed [31:0] y_c, x_c;
    logic               y_sat, x_sat;
    logic               coord_en;

    assign coord_en = accept && (i_s_tuser == OP_EVAL);

    p2d_coord #(.MAX_DIM(MAX_DIM)) u_row_coord (
        .i_clk(i_clk), .i_en(coord_en), .i_index(in_row),
        .i_offset(r_row_offset), .i_scale(r_row_scale),
        .o_coord(y_c), .o_sat(y_sat)
    );

    p2d_coord #(.MAX_DIM(MAX_DIM)) u_col_coord (
        .i_clk(i_clk), .i_en(coord_en), .i_index(in_col),
        .i_offset(r_col_offset), .i_scale(r_col_scale),
        .o_coord(x_c), .o_sat(x_sat)
    );

    // coefficient ring: cell 0 is the head, rotation moves cell k+1 into cell k
    logic signed [31:0] cell_val [COEFF_SLOTS];
    t_cell_ctl          cell_ctl [COEFF_SLOTS];
    logic [SW-1:0]      r_slot;
    logic               ring_shift;

    assign ring_shift = (r_state == ST_RUN) && (32'(r_slot) < 32'(COEFF_SLOTS));

    for (genvar k = 0; k < COEFF_SLOTS; k++) begin : g_cell
        assign cell_ctl[k].load  = accept && (i_s_tuser == OP_LOAD) &&
                                   (32'(in_cidx) == k);
        assign cell_ctl[k].shift = ring_shift;
        p2d_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(cell_ctl[k]),
            .i_load_value(in_cval),
            .i_next(cell_val[(k + 1) % COEFF_SLOTS]),
            .o_value(cell_val[k])
        );
    end

    // sequencer state
    logic [OW-1:0]      r_no, r_ni, r_a, r_b;
    logic signed [31:0] r_outer, r_inner, r_mono, r_major;
    logic               r_tdone, r_flag;
    logic signed [35:0] r_term;
    logic               r_tv;
    logic signed [47:0] r_acc;
    logic               r_ovalid;
    logic [47:0]        r_odata;
    logic               r_osat;

    // order clamping (the outer/inner choice is made in ST_COORD below)
    logic [OW-1:0] ox_c, oy_c;
    always_comb begin
        ox_c = (32'(r_order_x) > 32'(ORDER_CAP)) ? OW'(ORDER_CAP) : OW'(r_order_x);
        oy_c = (32'(r_order_y) > 32'(ORDER_CAP)) ? OW'(ORDER_CAP) : OW'(r_order_y);
    end

    // monomial step, term and accumulator sum
    logic               last_term, issue, inner_end, tdone_next;
    t_q28_res           m_inner, m_outer;
    logic signed [31:0] coef;
    logic signed [63:0] tprod;
    logic signed [48:0] sum;

    always_comb begin
        issue      = (r_state == ST_RUN) && !r_tdone;
        inner_end  = (r_b == (r_ni - r_a));
        last_term  = issue && inner_end && (r_a == r_no);
        tdone_next = r_tdone || last_term;
        m_inner    = mul_q28(r_inner, r_mono);
        m_outer    = mul_q28(r_outer, r_major);
        coef       = (32'(r_slot) < 32'(COEFF_SLOTS)) ? cell_val[0] : 32'sd0;
        tprod      = coef * r_mono;
        sum        = {r_acc[47], r_acc} + {{13{r_term[35]}}, r_term};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (coord_en) n_state = ST_COORD;
            ST_COORD: n_state = ST_RUN;
            ST_RUN: begin
                if (tdone_next && (32'(r_slot) + 1 >= 32'(COEFF_SLOTS))) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: n_state = ST_DRAIN;
            ST_DRAIN: if (!r_ovalid || i_m_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv     <= 1'b0;
            r_tdone  <= 1'b0;
            r_slot   <= '0;
            r_a      <= '0;
            r_b      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // a drained result fills the empty output register or replaces the one just taken
            if ((r_state == ST_DRAIN) && (!r_ovalid || i_m_tready)) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            r_tv <= issue;
            unique case (r_state)
                ST_COORD: begin
                    r_slot  <= '0;
                    r_tdone <= 1'b0;
                    r_a     <= '0;
                    r_b     <= '0;
                end
                ST_RUN: begin
                    r_tdone <= tdone_next;
                    if (32'(r_slot) < SEQ_MAX) r_slot <= r_slot + 1'b1;
                    if (issue && !last_term) begin
                        if (inner_end) begin
                            r_a <= r_a + 1'b1;
                            r_b <= '0;
                        end else begin
                            r_b <= r_b + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_COORD) begin
            r_flag  <= x_sat || y_sat;
            r_acc   <= '0;
            r_mono  <= Q28_ONE;
            r_major <= Q28_ONE;
            if (ox_c <= oy_c) begin
                r_no <= ox_c; r_ni <= oy_c; r_outer <= x_c; r_inner <= y_c;
            end else begin
                r_no <= oy_c; r_ni <= ox_c; r_outer <= y_c; r_inner <= x_c;
            end
        end else begin
            if (issue) begin
                r_term <= tprod[63:28];
                if (!last_term) begin
                    if (inner_end) begin
                        r_mono  <= m_outer.value;
                        r_major <= m_outer.value;
                        if (m_outer.sat) r_flag <= 1'b1;
                    end else begin
                        r_mono <= m_inner.value;
                        if (m_inner.sat) r_flag <= 1'b1;
                    end
                end
            end
            if (r_tv) begin
                if (sum[48] != sum[47]) begin
                    r_flag <= 1'b1;
                    r_acc  <= sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                end else begin
                    r_acc <= sum[47:0];
                end
            end
        end
        if ((r_state == ST_DRAIN) && (!r_ovalid || i_m_tready)) begin
            r_odata <= r_acc;
            r_osat  <= r_flag;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_osat;

    // checks
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_slot) <= SEQ_MAX)
        else $error("sequence counter overran");

    a_term_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tv |-> $past(r_state == ST_RUN))
        else $error("term issued outside run");

    a_inner_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && !r_tdone) |-> (r_b <= r_ni - r_a) && (r_a <= r_no))
        else $error("monomial counters out of range");

    a_drain_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN && n_state == ST_IDLE) |=> r_ovalid)
        else $error("result lost at drain");

endmodule

@@ hw/rtl/p2d_cell.sv @@
// One coefficient cell of the rotating coefficient ring.
// Depends on p2d_pkg.
module p2d_cell
    import p2d_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic signed [31:0] i_load_value,
    input  logic signed [31:0] i_next,
    output logic signed [31:0] o_value
);

    logic signed [31:0] r_coeff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff <= '0;
        end else if (i_ctl.load) begin
            r_coeff <= i_load_value;
        end else if (i_ctl.shift) begin
            r_coeff <= i_next;
        end
    end

    assign o_value = r_coeff;

endmodule

@@ hw/rtl/p2d_coord.sv @@
// Pixel index to Q4.28 coordinate: ((index*16 - offset) * scale) >> 4, saturated.
// Depends on p2d_pkg.
module p2d_coord
    import p2d_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [11:0]        i_index,
    input  logic signed [17:0] i_offset,
    input  logic signed [31:0] i_scale,
    output logic signed [31:0] o_coord,
    output logic               o_sat
);

    logic [11:0]        idx_c;
    logic signed [18:0] diff;
    logic signed [50:0] prod;
    logic signed [46:0] sh;
    logic               sat;
    logic signed [31:0] r_coord;
    logic               r_sat;

    always_comb begin
        idx_c = (32'(i_index) >= 32'(MAX_DIM)) ? 12'(MAX_DIM - 1) : i_index;
        diff  = $signed({3'b000, idx_c, 4'b0000}) - $signed({i_offset[17], i_offset});
        prod  = diff * i_scale;
        sh    = prod[50:4];
        sat   = !((&sh[46:31]) || (~|sh[46:31]));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat <= sat;
            if (sat) begin
                r_coord <= sh[46] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else begin
                r_coord <= sh[31:0];
            end
        end
    end

    assign o_coord = r_coord;
    assign o_sat   = r_sat;

endmodule
